>>> sv/mer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

    // Coordinate width of the center registers; every other datapath width follows from it.
    localparam int CB  = 10;
    localparam int RB  = CB - 1;         // radius width
    localparam int SQW = 2 * RB;         // width of a squared radius
    localparam int YW  = CB + 1;         // signed current y
    localparam int DW  = 3 * RB + 3;     // signed step terms dx and dy
    localparam int AW  = 4 * CB;         // signed decision value and accumulator
    localparam int MW  = 2 * CB + 1;     // multiplier operand width
    localparam int PW  = 2 * MW;         // multiplier product width
    localparam int PXW = CB + 2;         // signed pixel coordinate

    // Configuration port geometry.
    localparam int REG_IW = 2;
    localparam int REG_AW = REG_IW + 2;
    localparam int DATA_W = 32;

    localparam logic [REG_IW-1:0] REG_CENTER_X = 2'd0;
    localparam logic [REG_IW-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [REG_IW-1:0] REG_RADIUS_X = 2'd2;
    localparam logic [REG_IW-1:0] REG_RADIUS_Y = 2'd3;

    // Multiplier operations.
    localparam logic [3:0] MUL_NONE = 4'd0;
    localparam logic [3:0] MUL_RX2  = 4'd1;  // rx * rx
    localparam logic [3:0] MUL_RY2  = 4'd2;  // ry * ry
    localparam logic [3:0] MUL_T    = 4'd3;  // rx2 * ry
    localparam logic [3:0] MUL_P    = 4'd4;  // x * (x + 1)
    localparam logic [3:0] MUL_A1   = 4'd5;  // ry2 * product
    localparam logic [3:0] MUL_S    = 4'd6;  // (y - 1) squared
    localparam logic [3:0] MUL_A2   = 4'd7;  // rx2 * product
    localparam logic [3:0] MUL_RR   = 4'd8;  // rx2 * ry2

    // Accumulator operations.
    localparam logic [2:0] ACC_HOLD = 3'd0;
    localparam logic [2:0] ACC_LOAD = 3'd1;
    localparam logic [2:0] ACC_ADD  = 3'd2;
    localparam logic [2:0] ACC_SUB  = 3'd3;
    localparam logic [2:0] ACC_RYSQ = 3'd4;  // ry2 - product

    // Point state updates.
    localparam logic [2:0] UPD_HOLD  = 3'd0;
    localparam logic [2:0] UPD_INIT  = 3'd1;
    localparam logic [2:0] UPD_R2DEC = 3'd2;
    localparam logic [2:0] UPD_STEP  = 3'd3;
    localparam logic [2:0] UPD_DEC   = 3'd4;

    typedef struct packed {
        logic       latch;
        logic [3:0] mop;
        logic [2:0] acc_op;
        logic [2:0] upd_op;
        logic       r2;
        logic       out_load;
        logic [1:0] out_idx;
        logic       out_fin;
    } t_cmd;

    typedef struct packed {
        logic dx_lt_dy;
        logic y_neg;
    } t_status;

endpackage

`default_nettype wire

>>> sv/midpoint_ellipse_rasterizer_top.sv
// Midpoint ellipse rasterizer.
// Program center_x, center_y, radius_x and radius_y over the APB-style port
// (byte addresses 0, 4, 8 and 12) while the block is idle. Then send words on
// the input channel: a word with start_req set loads the first point of the
// ellipse and produces nothing; each word with start_req clear produces the
// four symmetric pixels of the current point on the output channel, the
// fourth one flagged with last_of_point, and finished set on every pixel of
// the final point. Once the ellipse is done, advance words produce nothing.
// A start word squares the radii on the one shared multiplier and then sets up
// the first point. An advance word squares the radii, updates the point and
// then the decision, and sends the pixels one word per cycle while the
// receiver is ready. The first advance of region two also runs the
// multiply and accumulate sequence that forms the region-two decision value.
// The first pixel is loaded into the output register after the step update.
// The last pixel sits in the output register while the next word is accepted.
// A stalled receiver simply holds the pixel register and the sequencer waits.
// Reset clears the configuration registers, the sequencer and the point state;
// the block then ignores advances until a start word arrives.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mer_pkg::REG_AW-1:0]            paddr,
    input  logic [mer_pkg::DATA_W-1:0]            pwdata,
    output logic [mer_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_start_req,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [mer_pkg::PXW-1:0]        o_pixel_x,
    output logic signed [mer_pkg::PXW-1:0]        o_pixel_y,
    output logic                                  o_last_of_point,
    output logic                                  o_finished
);
    import mer_pkg::*;

    logic [CB-1:0]     r_center_x, r_center_y;
    logic [RB-1:0]     r_radius_x, r_radius_y;
    logic [REG_IW-1:0] reg_idx;
    logic              reg_wr;
    t_cmd              cmd;
    t_status           status;

    // Register file. Writes complete in the access phase; the port never waits.
    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_AW-1:2];
    assign reg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius_x <= '0;
            r_radius_y <= '0;
        end else if (reg_wr) begin
            case (reg_idx)
                REG_CENTER_X: r_center_x <= pwdata[CB-1:0];
                REG_CENTER_Y: r_center_y <= pwdata[CB-1:0];
                REG_RADIUS_X: r_radius_x <= pwdata[RB-1:0];
                REG_RADIUS_Y: r_radius_y <= pwdata[RB-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER_X: prdata = DATA_W'(r_center_x);
            REG_CENTER_Y: prdata = DATA_W'(r_center_y);
            REG_RADIUS_X: prdata = DATA_W'(r_radius_x);
            REG_RADIUS_Y: prdata = DATA_W'(r_radius_y);
            default:      prdata = '0;
        endcase
    end

    // The sequencer owns the handshakes and the region; the datapath owns the
    // arithmetic, the point state and the pixel register.
    mer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_req (i_start_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    mer_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_center_x      (r_center_x),
        .i_center_y      (r_center_y),
        .i_radius_x      (r_radius_x),
        .i_radius_y      (r_radius_y),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_point (o_last_of_point),
        .o_finished      (o_finished)
    );

`ifndef SYNTHESIS
    // An accepted word leaves the sequencer busy in the cycle after it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted on two consecutive cycles");

    // The four pixels of a point leave without gaps when the receiver takes them.
    a_point_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_of_point) |=> o_valid)
        else $error("gap inside the pixels of one point");

    // The word after the last pixel of a point starts a new point.
    a_last_not_repeated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_of_point) |=> (!o_valid || !o_last_of_point))
        else $error("last pixel flag on two consecutive words");
`endif

endmodule

`default_nettype wire

>>> sv/mer_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mer_pkg::t_cmd                     i_cmd,
    output mer_pkg::t_status                  o_status,
    input  logic [mer_pkg::CB-1:0]            i_center_x,
    input  logic [mer_pkg::CB-1:0]            i_center_y,
    input  logic [mer_pkg::RB-1:0]            i_radius_x,
    input  logic [mer_pkg::RB-1:0]            i_radius_y,
    output logic signed [mer_pkg::PXW-1:0]    o_pixel_x,
    output logic signed [mer_pkg::PXW-1:0]    o_pixel_y,
    output logic                              o_last_of_point,
    output logic                              o_finished
);
    import mer_pkg::*;

    typedef logic signed [AW-1:0]  t_dec;
    typedef logic signed [DW-1:0]  t_step;
    typedef logic [MW-1:0]         t_mop;
    typedef logic signed [PXW-1:0] t_pix;

    logic [RB-1:0]          r_rx, r_ry;
    logic [SQW-1:0]         r_rx2, r_ry2;
    logic [PW-1:0]          r_prod;
    t_dec                   r_acc;
    logic [CB-1:0]          r_x, r_px;
    logic signed [YW-1:0]   r_y, r_py;
    t_step                  r_dx, r_dy;
    t_dec                   r_dec;
    logic                   r_plain;
    t_pix                   r_pix_x, r_pix_y;
    logic                   r_last, r_fin;

    t_mop                   op_a, op_b;
    logic [PW-1:0]          mul_p;
    logic [CB:0]            x_inc;
    logic signed [YW-1:0]   ym1;
    logic [YW-1:0]          ym1_abs;
    t_step                  ry2_step, rx2_step;
    t_dec                   prod_d, rx2_d, ry2_d, dx_d, dy_d, dec_term, dec_const;
    logic                   step_plain;
    t_pix                   px_e, py_e, cx_e, cy_e;

    // Quarter-scale start values are truncated toward zero.
    function automatic t_dec trunc_quarter(input t_dec a, input logic [SQW-1:0] b);
        t_dec q;
        q = a + t_dec'(b >> 2);
        if (q[AW-1] && (b[1:0] != 2'b00)) begin
            q = q + t_dec'(1);
        end
        return q;
    endfunction

    assign x_inc   = {1'b0, r_x} + {{CB{1'b0}}, 1'b1};
    assign ym1     = r_y - {{(YW-1){1'b0}}, 1'b1};
    assign ym1_abs = ym1[YW-1] ? (~ym1 + {{(YW-1){1'b0}}, 1'b1}) : ym1;

    // Single shared multiplier.
    always_comb begin
        case (i_cmd.mop)
            MUL_RX2: begin
                op_a = t_mop'(r_rx);
                op_b = t_mop'(r_rx);
            end
            MUL_RY2: begin
                op_a = t_mop'(r_ry);
                op_b = t_mop'(r_ry);
            end
            MUL_T: begin
                op_a = t_mop'(r_rx2);
                op_b = t_mop'(r_ry);
            end
            MUL_P: begin
                op_a = t_mop'(r_x);
                op_b = t_mop'(x_inc);
            end
            MUL_A1: begin
                op_a = t_mop'(r_ry2);
                op_b = r_prod[MW-1:0];
            end
            MUL_S: begin
                op_a = t_mop'(ym1_abs);
                op_b = t_mop'(ym1_abs);
            end
            MUL_A2: begin
                op_a = t_mop'(r_rx2);
                op_b = r_prod[MW-1:0];
            end
            MUL_RR: begin
                op_a = t_mop'(r_rx2);
                op_b = t_mop'(r_ry2);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_p = op_a * op_b;

    assign ry2_step = t_step'({r_ry2, 1'b0});
    assign rx2_step = t_step'({r_rx2, 1'b0});
    assign prod_d   = r_prod[AW-1:0];
    assign rx2_d    = t_dec'(r_rx2);
    assign ry2_d    = t_dec'(r_ry2);
    assign dx_d     = t_dec'(r_dx);
    assign dy_d     = t_dec'(r_dy);

    // Region one steps along x alone unless the decision is non-negative; region two
    // steps along y alone unless the decision is not positive.
    assign step_plain = i_cmd.r2 ? (!r_dec[AW-1] && (r_dec != '0)) : r_dec[AW-1];

    always_comb begin
        if (r_plain) begin
            dec_term = i_cmd.r2 ? -dy_d : dx_d;
        end else begin
            dec_term = dx_d - dy_d;
        end
        dec_const = i_cmd.r2 ? rx2_d : ry2_d;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_rx <= i_radius_x;
            r_ry <= i_radius_y;
        end
        case (i_cmd.mop)
            MUL_NONE: begin
            end
            MUL_RX2: begin
                r_rx2 <= mul_p[SQW-1:0];
            end
            MUL_RY2: begin
                r_ry2 <= mul_p[SQW-1:0];
            end
            default: begin
                r_prod <= mul_p;
            end
        endcase
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= prod_d;
            ACC_ADD:  r_acc <= r_acc + prod_d;
            ACC_SUB:  r_acc <= r_acc - prod_d;
            ACC_RYSQ: r_acc <= ry2_d - prod_d;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_dec   <= '0;
            r_plain <= 1'b0;
        end else begin
            case (i_cmd.upd_op)
                UPD_INIT: begin
                    r_x   <= '0;
                    r_y   <= {{(YW-RB){1'b0}}, r_ry};
                    r_dx  <= '0;
                    r_dy  <= {r_prod[DW-2:0], 1'b0};
                    r_dec <= trunc_quarter(r_acc, r_rx2);
                end
                UPD_R2DEC: begin
                    r_dec <= trunc_quarter(r_acc, r_ry2);
                end
                UPD_STEP: begin
                    r_plain <= step_plain;
                    if (!i_cmd.r2) begin
                        r_x  <= x_inc[CB-1:0];
                        r_dx <= r_dx + ry2_step;
                        if (!step_plain) begin
                            r_y  <= ym1;
                            r_dy <= r_dy - rx2_step;
                        end
                    end else begin
                        r_y  <= ym1;
                        r_dy <= r_dy - rx2_step;
                        if (!step_plain) begin
                            r_x  <= x_inc[CB-1:0];
                            r_dx <= r_dx + ry2_step;
                        end
                    end
                end
                UPD_DEC: begin
                    r_dec <= r_dec + dec_term + dec_const;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_op == UPD_STEP) begin
            r_px <= r_x;
            r_py <= r_y;
        end
    end

    // Symmetric pixels: bit 0 of the index mirrors x, bit 1 mirrors y.
    assign px_e = {2'b00, r_px};
    assign py_e = {r_py[YW-1], r_py};
    assign cx_e = {2'b00, i_center_x};
    assign cy_e = {2'b00, i_center_y};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pix_x <= i_cmd.out_idx[0] ? (cx_e - px_e) : (cx_e + px_e);
            r_pix_y <= i_cmd.out_idx[1] ? (cy_e - py_e) : (cy_e + py_e);
            r_last  <= (i_cmd.out_idx == 2'd3);
            r_fin   <= i_cmd.out_fin;
        end
    end

    assign o_status.dx_lt_dy = (r_dx < r_dy);
    assign o_status.y_neg    = r_y[YW-1];

    assign o_pixel_x       = r_pix_x;
    assign o_pixel_y       = r_pix_y;
    assign o_last_of_point = r_last;
    assign o_finished      = r_fin;

endmodule

`default_nettype wire

>>> sv/mer_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_start_req,
    output logic              o_valid,
    input  logic              i_ready,
    output mer_pkg::t_cmd     o_cmd,
    input  mer_pkg::t_status  i_status
);
    import mer_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MRX  = 5'd1;
    localparam logic [4:0] S_MRY  = 5'd2;
    localparam logic [4:0] S_MT   = 5'd3;
    localparam logic [4:0] S_SA   = 5'd4;
    localparam logic [4:0] S_SB   = 5'd5;
    localparam logic [4:0] S_P    = 5'd6;
    localparam logic [4:0] S_A1   = 5'd7;
    localparam logic [4:0] S_S    = 5'd8;
    localparam logic [4:0] S_A2   = 5'd9;
    localparam logic [4:0] S_C    = 5'd10;
    localparam logic [4:0] S_D    = 5'd11;
    localparam logic [4:0] S_E    = 5'd12;
    localparam logic [4:0] S_U1   = 5'd13;
    localparam logic [4:0] S_U2   = 5'd14;
    localparam logic [4:0] S_EMIT = 5'd15;

    localparam logic [1:0] REGION_IDLE = 2'd0;
    localparam logic [1:0] REGION_ONE  = 2'd1;
    localparam logic [1:0] REGION_TWO  = 2'd2;

    logic [4:0] r_state, n_state;
    logic [1:0] r_region, n_region;
    logic       r_start, n_start;
    logic [1:0] r_idx, n_idx;
    logic       r_fin, n_fin;
    logic       r_ovalid, n_ovalid;
    t_cmd       cmd;
    logic       fin_now;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_cmd   = cmd;

    assign fin_now = (r_region == REGION_TWO) ? i_status.y_neg
                                              : (!i_status.dx_lt_dy && i_status.y_neg);

    always_comb begin
        n_state  = r_state;
        n_region = r_region;
        n_start  = r_start;
        n_idx    = r_idx;
        n_fin    = r_fin;
        cmd      = '0;
        cmd.r2   = (r_region == REGION_TWO);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.latch = 1'b1;
                    n_start   = i_start_req;
                    n_state   = S_MRX;
                end
            end
            S_MRX: begin
                cmd.mop = MUL_RX2;
                n_state = S_MRY;
            end
            S_MRY: begin
                cmd.mop = MUL_RY2;
                if (r_start) begin
                    n_state = S_MT;
                end else begin
                    case (r_region)
                        REGION_ONE: begin
                            n_state = i_status.dx_lt_dy ? S_U1 : S_P;
                        end
                        REGION_TWO: begin
                            if (i_status.y_neg) begin
                                n_region = REGION_IDLE;
                                n_state  = S_IDLE;
                            end else begin
                                n_state = S_U1;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MT: begin
                cmd.mop = MUL_T;
                n_state = S_SA;
            end
            S_SA: begin
                cmd.acc_op = ACC_RYSQ;
                n_state    = S_SB;
            end
            S_SB: begin
                cmd.upd_op = UPD_INIT;
                n_region   = REGION_ONE;
                n_state    = S_IDLE;
            end
            S_P: begin
                cmd.mop = MUL_P;
                n_state = S_A1;
            end
            S_A1: begin
                cmd.mop = MUL_A1;
                n_state = S_S;
            end
            S_S: begin
                cmd.mop    = MUL_S;
                cmd.acc_op = ACC_LOAD;
                n_state    = S_A2;
            end
            S_A2: begin
                cmd.mop = MUL_A2;
                n_state = S_C;
            end
            S_C: begin
                cmd.mop    = MUL_RR;
                cmd.acc_op = ACC_ADD;
                n_state    = S_D;
            end
            S_D: begin
                cmd.acc_op = ACC_SUB;
                n_state    = S_E;
            end
            S_E: begin
                cmd.upd_op = UPD_R2DEC;
                if (i_status.y_neg) begin
                    n_region = REGION_IDLE;
                    n_state  = S_IDLE;
                end else begin
                    n_region = REGION_TWO;
                    n_state  = S_U1;
                end
            end
            S_U1: begin
                cmd.upd_op = UPD_STEP;
                n_state    = S_U2;
            end
            S_U2: begin
                cmd.upd_op = UPD_DEC;
                n_fin      = fin_now;
                n_idx      = 2'd0;
                if (fin_now) begin
                    n_region = REGION_IDLE;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_idx  = r_idx;
                    cmd.out_fin  = r_fin;
                    n_idx        = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_ovalid = cmd.out_load ? 1'b1 : (i_ready ? 1'b0 : r_ovalid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_region <= REGION_IDLE;
            r_start  <= 1'b0;
            r_idx    <= 2'd0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_region <= n_region;
            r_start  <= n_start;
            r_idx    <= n_idx;
            r_fin    <= n_fin;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

typedef enum logic [1:0] {
    ARC_IDLE  = 2'd0,
    ARC_UPPER = 2'd1,
    ARC_LOWER = 2'd2
} t_arc;

typedef struct {
    logic signed [mer_pkg::PXW-1:0] x;
    logic signed [mer_pkg::PXW-1:0] y;
    logic                           last;
    logic                           fin;
} t_pixel;

// Tracks the ellipse the block should be drawing and the pixels still owed.
class ellipse_tracker;
    logic [mer_pkg::CB-1:0] center_x;
    logic [mer_pkg::CB-1:0] center_y;
    logic [mer_pkg::RB-1:0] radius_x;
    logic [mer_pkg::RB-1:0] radius_y;
    longint cur_x, cur_y, step_dx, step_dy, decision;
    t_arc   arc;
    t_pixel expected_pixels[$];
    int     mismatches;
    int     pixels_seen;
    int     ellipses_done;

    function new();
        center_x = '0;
        center_y = '0;
        radius_x = '0;
        radius_y = '0;
        cur_x = 0;
        cur_y = 0;
        step_dx = 0;
        step_dy = 0;
        decision = 0;
        arc = ARC_IDLE;
        mismatches = 0;
        pixels_seen = 0;
        ellipses_done = 0;
    endfunction

    function void set_reg(logic [mer_pkg::REG_IW-1:0] idx, logic [31:0] value);
        case (idx)
            mer_pkg::REG_CENTER_X: center_x = value[mer_pkg::CB-1:0];
            mer_pkg::REG_CENTER_Y: center_y = value[mer_pkg::CB-1:0];
            mer_pkg::REG_RADIUS_X: radius_x = value[mer_pkg::RB-1:0];
            mer_pkg::REG_RADIUS_Y: radius_y = value[mer_pkg::RB-1:0];
            default: ;
        endcase
    endfunction

    // (4*a + b) / 4 truncated toward zero, b never negative.
    function longint quarter_trunc(longint a, longint b);
        longint q;
        q = a + (b >>> 2);
        if (q < 0 && b[1:0] != 2'b00)
            q += 1;
        return q;
    endfunction

    function void push_point(longint x, longint y, logic fin);
        logic [63:0] wide;
        t_pixel      p;
        for (int k = 0; k < 4; k++) begin
            wide = (k[0] ? -x : x) + longint'(center_x);
            p.x = wide[mer_pkg::PXW-1:0];
            wide = (k[1] ? -y : y) + longint'(center_y);
            p.y = wide[mer_pkg::PXW-1:0];
            p.last = (k == 3);
            p.fin = fin;
            expected_pixels.push_back(p);
        end
    endfunction

    function void note_word(logic start_req);
        longint rx, ry, rx2, ry2, ym1, a, px, py;
        logic   fin;
        rx = longint'(radius_x);
        ry = longint'(radius_y);
        rx2 = rx * rx;
        ry2 = ry * ry;
        if (start_req) begin
            cur_x = 0;
            cur_y = ry;
            decision = quarter_trunc(ry2 - rx2 * ry, rx2);
            step_dx = 0;
            step_dy = 2 * rx2 * ry;
            arc = ARC_UPPER;
            return;
        end
        // The upper arc may already be over, even on the first advance.
        if (arc == ARC_UPPER && !(step_dx < step_dy)) begin
            ym1 = cur_y - 1;
            a = ry2 * (cur_x * cur_x + cur_x) + rx2 * ym1 * ym1 - rx2 * ry2;
            decision = quarter_trunc(a, ry2);
            arc = ARC_LOWER;
        end
        if (arc == ARC_UPPER) begin
            px = cur_x;
            py = cur_y;
            cur_x += 1;
            step_dx += 2 * ry2;
            if (decision < 0) begin
                decision += step_dx + ry2;
            end else begin
                cur_y -= 1;
                step_dy -= 2 * rx2;
                decision += step_dx - step_dy + ry2;
            end
            fin = !(step_dx < step_dy) && cur_y < 0;
            if (fin)
                arc = ARC_IDLE;
            push_point(px, py, fin);
        end else if (arc == ARC_LOWER) begin
            if (cur_y < 0) begin
                arc = ARC_IDLE;
            end else begin
                px = cur_x;
                py = cur_y;
                cur_y -= 1;
                step_dy -= 2 * rx2;
                if (decision > 0) begin
                    decision += rx2 - step_dy;
                end else begin
                    cur_x += 1;
                    step_dx += 2 * ry2;
                    decision += step_dx - step_dy + rx2;
                end
                fin = cur_y < 0;
                if (fin)
                    arc = ARC_IDLE;
                push_point(px, py, fin);
            end
        end
    endfunction

    function bit busy();
        return arc != ARC_IDLE;
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    function void check_pixel(logic signed [mer_pkg::PXW-1:0] px,
                              logic signed [mer_pkg::PXW-1:0] py,
                              logic last, logic fin);
        t_pixel want;
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel: expected none, got x=%0d y=%0d last=%0b fin=%0b",
                         px, py, last, fin);
            return;
        end
        want = expected_pixels.pop_front();
        if (want.last && want.fin)
            ellipses_done++;
        if (want.x !== px || want.y !== py || want.last !== last || want.fin !== fin) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"pixel mismatch: expected x=%0d y=%0d last=%0b fin=%0b,",
                          " got x=%0d y=%0d last=%0b fin=%0b"},
                         want.x, want.y, want.last, want.fin, px, py, last, fin);
        end
    endfunction
endclass

module tb_top;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [mer_pkg::REG_AW-1:0]        paddr;
    logic [mer_pkg::DATA_W-1:0]        pwdata;
    logic [mer_pkg::DATA_W-1:0]        prdata;
    logic                              pready;
    logic                              i_valid;
    logic                              o_ready;
    logic                              i_start_req;
    logic                              o_valid;
    logic                              i_ready;
    logic signed [mer_pkg::PXW-1:0]    o_pixel_x;
    logic signed [mer_pkg::PXW-1:0]    o_pixel_y;
    logic                              o_last_of_point;
    logic                              o_finished;

    int send_idle_pct = 9;
    int recv_idle_pct = 74;
    int pressure_asks = 0;
    int words_sent = 0;
    int starts_sent = 0;

    ellipse_tracker trk;

    midpoint_ellipse_rasterizer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_start_req     (i_start_req),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_point (o_last_of_point),
        .o_finished      (o_finished)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Far beyond the slowest correct run, even with every pixel stalled.
    initial begin
        #4_000_000;
        $display("tb_top failed");
        $finish;
    end

    // Pixel receiver. A pressure request holds ready low so that the block backs
    // up and stops taking words.
    initial begin : receiver
        int served;
        served = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (served < pressure_asks) begin
                served++;
                i_ready <= 1'b0;
                repeat (399) @(negedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            trk.check_pixel(o_pixel_x, o_pixel_y, o_last_of_point, o_finished);
    end

    // Offers one word and returns at the falling edge after it was taken.
    task automatic send_word(input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_req <= start;
        do @(posedge i_clk); while (!o_ready);
        trk.note_word(start);
        words_sent++;
        if (start)
            starts_sent++;
        @(negedge i_clk);
    endtask

    // Waits for every owed pixel, then lets a start word or a silent advance
    // finish in the block before anything else happens.
    task automatic settle();
        i_valid <= 1'b0;
        while (trk.pending() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mer_pkg::REG_IW-1:0] idx,
                             input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        trk.set_reg(idx, value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_ellipse(input int unsigned cx, input int unsigned cy,
                                input int unsigned rx, input int unsigned ry);
        settle();
        write_reg(mer_pkg::REG_CENTER_X, cx);
        write_reg(mer_pkg::REG_CENTER_Y, cy);
        write_reg(mer_pkg::REG_RADIUS_X, rx);
        write_reg(mer_pkg::REG_RADIUS_Y, ry);
    endtask

    task automatic run_out(input int cap);
        int n;
        n = 0;
        while (trk.busy() && n < cap) begin
            send_word(1'b0);
            n++;
        end
    endtask

    initial begin
        int          counted;
        int          guard;
        int          pick;
        logic        stretch;
        int unsigned rx, ry;

        trk = new();
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_start_req = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // An advance straight out of reset must be ignored.
        send_word(1'b0);

        // Degenerate ellipse: a single point, then an advance after the end.
        load_ellipse(5, 7, 0, 0);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);

        // Flat ellipse around the origin: a zero vertical radius, so it ends after its first point.
        load_ellipse(0, 0, 3, 0);
        send_word(1'b1);
        send_word(1'b0);

        // Vertical line at the far corner; the horizontal radius changes
        // in the middle, and the remaining steps must follow the new value.
        load_ellipse(1023, 1023, 0, 3);
        send_word(1'b1);
        send_word(1'b0);
        settle();
        write_reg(mer_pkg::REG_RADIUS_X, 2);
        run_out(4);

        // Largest radii for a few points, a live center move, and a restart.
        load_ellipse(512, 512, 511, 511);
        send_word(1'b1);
        repeat (3) send_word(1'b0);
        settle();
        write_reg(mer_pkg::REG_CENTER_X, 1023);
        write_reg(mer_pkg::REG_CENTER_Y, 0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);

        // A tall, thin ellipse reaches the lower arc on its second advance.
        load_ellipse(300, 700, 1, 511);
        send_word(1'b1);
        repeat (3) send_word(1'b0);

        // Random ellipses, mostly traced to their end, with restarts, live
        // center moves and stray advances mixed in.
        counted = 0;
        while (counted < 100 || pressure_asks == 0) begin
            if (counted >= 66) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (counted >= 33) begin
                send_idle_pct = 74;
                recv_idle_pct = 9;
            end
            stretch = (counted >= 50 && pressure_asks == 0);
            if (stretch || counted == 0 || $urandom_range(3) != 0) begin
                if (stretch) begin
                    rx = $urandom_range(30, 16);
                    ry = $urandom_range(30, 16);
                end else if ($urandom_range(4) == 0) begin
                    rx = $urandom_range(30);
                    ry = $urandom_range(30);
                end else begin
                    rx = $urandom_range(10);
                    ry = $urandom_range(10);
                end
                load_ellipse($urandom_range(1023), $urandom_range(1023), rx, ry);
            end
            send_word(1'b1);
            counted++;
            if (stretch)
                pressure_asks++;
            guard = 0;
            while (trk.busy() && guard < (stretch ? 30 : 200)) begin
                pick = $urandom_range(99);
                if (pick < 3) begin
                    send_word(1'b1);
                    counted++;
                end else if (pick < 5) begin
                    settle();
                    write_reg(mer_pkg::REG_CENTER_Y, $urandom_range(1023));
                end else begin
                    send_word(1'b0);
                    counted++;
                end
                guard++;
            end
            repeat ($urandom_range(2)) send_word(1'b0);
        end

        settle();
        $display("Run covered %0d words (%0d starts), %0d pixels, %0d ellipses to the end.",
                 words_sent, starts_sent, trk.pixels_seen, trk.ellipses_done);
        $display("Output held off %0d time(s) for 400 cycles; %0d mismatches, %0d owed.",
                 pressure_asks, trk.mismatches, trk.pending());
        if (trk.mismatches == 0 && trk.pending() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/mer_pkg.sv
sv/mer_dp.sv
sv/mer_ctrl.sv
sv/midpoint_ellipse_rasterizer_top.sv
tb/tb_top.sv
